FILE: src/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg
// shared constants, types and helpers of the next-fit heap allocator
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int HEAP_UNITS = 4096;
    localparam int UNIT_BYTES = 16;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
    localparam int IDX_W      = $clog2(HEAP_UNITS);
    localparam int SIZE_W     = IDX_W + 1;
    localparam int WALK_LIMIT = HEAP_UNITS + 2;
    localparam int CNT_W      = $clog2(WALK_LIMIT + 1);
    localparam int BYTES_W    = 16;
    localparam int ENTRY_W    = IDX_W + SIZE_W;

    localparam logic OP_ALLOC    = 1'b0;
    localparam logic OP_FREE     = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NO_SPACE = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]  link;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef enum logic [3:0] {
        S_INIT0, S_INIT1, S_IDLE, S_A_ROV, S_A_CHECK, S_A_SPLIT,
        S_F_WALK, S_F_BLK, S_F_NX, S_F_WB, S_F_WP, S_RESULT
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_INIT0, CMD_INIT1, CMD_START, CMD_A_ROV, CMD_A_CHECK,
        CMD_A_SPLIT, CMD_F_WALK, CMD_F_BLK, CMD_F_NX, CMD_F_WB, CMD_F_WP
    } t_cmd;

    typedef struct packed {
        logic in_free;
        logic in_bad;
        logic limit;
        logic fit;
        logic exact;
        logic at_rover;
        logic found;
        logic merge_next;
    } t_dp_status;

    function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > (SIZE_W+1)'(HEAP_UNITS)) begin
            return SIZE_W'(HEAP_UNITS);
        end
        return s[SIZE_W-1:0];
    endfunction

endpackage

FILE: src/nfa_req_if.sv
// ----------------------------------------------------------------------------
// nfa_req_if
// request channel: operation, byte count and block address
// ----------------------------------------------------------------------------
interface nfa_req_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [nfa_pkg::BYTES_W-1:0]     request_bytes;
    logic [nfa_pkg::IDX_W-1:0]       block_address;

    modport source (output valid, operation, request_bytes, block_address, input ready);
    modport sink   (input valid, operation, request_bytes, block_address, output ready);
endinterface

FILE: src/nfa_rsp_if.sv
// ----------------------------------------------------------------------------
// nfa_rsp_if
// response channel: status, data address and granted units
// ----------------------------------------------------------------------------
interface nfa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [nfa_pkg::IDX_W-1:0]   data_address;
    logic [nfa_pkg::IDX_W-1:0]   granted_units;

    modport source (output valid, status, data_address, granted_units, input ready);
    modport sink   (input valid, status, data_address, granted_units, output ready);
endinterface

FILE: src/nfa_ram.sv
// ----------------------------------------------------------------------------
// nfa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module nfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/nfa_datapath.sv
// ----------------------------------------------------------------------------
// nfa_datapath
// header store, walk pointers, split and merge arithmetic, result registers
// ----------------------------------------------------------------------------
module nfa_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nfa_pkg::t_cmd                 i_cmd,
    input  logic                          i_operation,
    input  logic [nfa_pkg::BYTES_W-1:0]   i_request_bytes,
    input  logic [nfa_pkg::IDX_W-1:0]     i_block_address,
    output nfa_pkg::t_dp_status           o_status,
    output logic                          o_res_status,
    output logic [nfa_pkg::IDX_W-1:0]     o_res_address,
    output logic [nfa_pkg::IDX_W-1:0]     o_res_units
);
    localparam int IW = nfa_pkg::IDX_W;
    localparam int SW = nfa_pkg::SIZE_W;
    localparam int CW = nfa_pkg::CNT_W;
    localparam int BYTES_W_P1 = nfa_pkg::BYTES_W + 1;

    logic [IW-1:0] r_rover, n_rover;
    logic [IW-1:0] r_prev, n_prev;
    logic [SW-1:0] r_prev_sz, n_prev_sz;
    logic [IW-1:0] r_cur, n_cur;
    logic [SW-1:0] r_need, n_need;
    logic [IW-1:0] r_blk, n_blk;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_nx, n_nx;
    logic [SW-1:0] r_bsz, n_bsz;
    logic [IW-1:0] r_blink, n_blink;
    logic [IW-1:0] r_newcur, n_newcur;
    logic          r_res_st, n_res_st;
    logic [IW-1:0] r_res_addr, n_res_addr;
    logic [IW-1:0] r_res_units, n_res_units;

    logic                  we;
    logic [IW-1:0]         waddr;
    nfa_pkg::t_entry       wentry;
    logic [IW-1:0]         raddr;
    logic [nfa_pkg::ENTRY_W-1:0] rdata;
    nfa_pkg::t_entry       rd;

    logic [SW-1:0]         need_in;
    logic [BYTES_W_P1-1:0] bytes_up;
    logic [SW-1:0]         rest;
    logic [IW-1:0]         split_at;
    logic [SW:0]           blk_end;
    logic [SW:0]           p_end;

    nfa_ram #(.WIDTH(nfa_pkg::ENTRY_W), .DEPTH(nfa_pkg::HEAP_UNITS)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wentry),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd       = nfa_pkg::t_entry'(rdata);
    assign bytes_up = {1'b0, i_request_bytes} + BYTES_W_P1'(nfa_pkg::UNIT_BYTES - 1);
    assign need_in  = SW'(bytes_up >> nfa_pkg::UNIT_SHIFT) + SW'(1);
    assign rest     = rd.size - r_need;
    assign split_at = r_cur + rest[IW-1:0];
    assign blk_end  = {2'b00, r_blk} + {1'b0, rd.size};
    assign p_end    = {2'b00, r_prev} + {1'b0, r_prev_sz};

    always_comb begin
        o_status.in_free    = (i_operation == nfa_pkg::OP_FREE);
        o_status.in_bad     = (i_block_address < IW'(2));
        o_status.limit      = (r_cnt == CW'(nfa_pkg::WALK_LIMIT));
        o_status.fit        = (rd.size >= r_need);
        o_status.exact      = (rd.size == r_need);
        o_status.at_rover   = (r_cur == r_rover);
        o_status.found      = (r_blk > r_prev && r_blk < rd.link) ||
                              (r_prev >= rd.link && (r_blk > r_prev || r_blk < rd.link));
        o_status.merge_next = (blk_end == {2'b00, r_nx});
    end

    always_comb begin
        n_rover     = r_rover;
        n_prev      = r_prev;
        n_prev_sz   = r_prev_sz;
        n_cur       = r_cur;
        n_need      = r_need;
        n_blk       = r_blk;
        n_cnt       = r_cnt;
        n_nx        = r_nx;
        n_bsz       = r_bsz;
        n_blink     = r_blink;
        n_newcur    = r_newcur;
        n_res_st    = r_res_st;
        n_res_addr  = r_res_addr;
        n_res_units = r_res_units;
        we          = 1'b0;
        waddr       = r_prev;
        wentry      = '{link: r_blink, size: r_bsz};
        raddr       = r_rover;
        unique case (i_cmd)
            nfa_pkg::CMD_NONE: begin
            end
            nfa_pkg::CMD_INIT0: begin
                we     = 1'b1;
                waddr  = '0;
                wentry = '{link: IW'(1), size: '0};
            end
            nfa_pkg::CMD_INIT1: begin
                we     = 1'b1;
                waddr  = IW'(1);
                wentry = '{link: '0, size: SW'(nfa_pkg::HEAP_UNITS - 1)};
            end
            nfa_pkg::CMD_START: begin
                n_need      = need_in;
                n_blk       = i_block_address - IW'(1);
                n_prev      = r_rover;
                n_cnt       = '0;
                n_res_st    = nfa_pkg::ST_OK;
                n_res_addr  = '0;
                n_res_units = '0;
            end
            nfa_pkg::CMD_A_ROV: begin
                n_prev_sz = rd.size;
                n_cur     = rd.link;
                raddr     = rd.link;
            end
            nfa_pkg::CMD_A_CHECK: begin
                priority if (o_status.limit) begin
                    n_res_st = nfa_pkg::ST_NO_SPACE;
                end else if (o_status.fit && o_status.exact) begin
                    we          = 1'b1;
                    waddr       = r_prev;
                    wentry      = '{link: rd.link, size: r_prev_sz};
                    n_rover     = r_prev;
                    n_res_addr  = r_cur + IW'(1);
                    n_res_units = r_need[IW-1:0];
                end else if (o_status.fit) begin
                    we       = 1'b1;
                    waddr    = r_cur;
                    wentry   = '{link: rd.link, size: rest};
                    n_newcur = split_at;
                    raddr    = split_at;
                    n_rover  = r_prev;
                end else if (o_status.at_rover) begin
                    n_res_st = nfa_pkg::ST_NO_SPACE;
                end else begin
                    n_prev    = r_cur;
                    n_prev_sz = rd.size;
                    n_cur     = rd.link;
                    raddr     = rd.link;
                    n_cnt     = r_cnt + CW'(1);
                end
            end
            nfa_pkg::CMD_A_SPLIT: begin
                we          = 1'b1;
                waddr       = r_newcur;
                wentry      = '{link: rd.link, size: r_need};
                n_res_addr  = r_newcur + IW'(1);
                n_res_units = r_need[IW-1:0];
            end
            nfa_pkg::CMD_F_WALK: begin
                priority if (o_status.limit) begin
                    n_res_st = nfa_pkg::ST_OK;
                end else if (o_status.found) begin
                    n_prev_sz = rd.size;
                    n_nx      = rd.link;
                    raddr     = r_blk;
                end else begin
                    n_prev = rd.link;
                    raddr  = rd.link;
                    n_cnt  = r_cnt + CW'(1);
                end
            end
            nfa_pkg::CMD_F_BLK: begin
                n_bsz = rd.size;
                if (o_status.merge_next) begin
                    raddr = r_nx;
                end else begin
                    n_blink = r_nx;
                end
            end
            nfa_pkg::CMD_F_NX: begin
                n_bsz   = nfa_pkg::sat_add(r_bsz, rd.size);
                n_blink = rd.link;
            end
            nfa_pkg::CMD_F_WB: begin
                we     = 1'b1;
                waddr  = r_blk;
                wentry = '{link: r_blink, size: r_bsz};
            end
            nfa_pkg::CMD_F_WP: begin
                we      = 1'b1;
                waddr   = r_prev;
                n_rover = r_prev;
                if (p_end == {2'b00, r_blk}) begin
                    wentry = '{link: r_blink, size: nfa_pkg::sat_add(r_prev_sz, r_bsz)};
                end else begin
                    wentry = '{link: r_blk, size: r_prev_sz};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover <= '0;
        end else begin
            r_rover <= n_rover;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev      <= n_prev;
        r_prev_sz   <= n_prev_sz;
        r_cur       <= n_cur;
        r_need      <= n_need;
        r_blk       <= n_blk;
        r_cnt       <= n_cnt;
        r_nx        <= n_nx;
        r_bsz       <= n_bsz;
        r_blink     <= n_blink;
        r_newcur    <= n_newcur;
        r_res_st    <= n_res_st;
        r_res_addr  <= n_res_addr;
        r_res_units <= n_res_units;
    end

    assign o_res_status  = r_res_st;
    assign o_res_address = r_res_addr;
    assign o_res_units   = r_res_units;
endmodule

FILE: src/nfa_ctrl.sv
// ----------------------------------------------------------------------------
// nfa_ctrl
// sequencer for header store init, allocation walk and free walk with merge
// ----------------------------------------------------------------------------
module nfa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_free,
    input  nfa_pkg::t_dp_status   i_status,
    output logic                  o_in_ready,
    output logic                  o_out_load,
    output nfa_pkg::t_cmd         o_cmd
);
    nfa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nfa_pkg::S_INIT0;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        o_cmd      = nfa_pkg::CMD_NONE;
        unique case (r_state)
            nfa_pkg::S_INIT0: begin
                o_cmd   = nfa_pkg::CMD_INIT0;
                n_state = nfa_pkg::S_INIT1;
            end
            nfa_pkg::S_INIT1: begin
                o_cmd   = nfa_pkg::CMD_INIT1;
                n_state = nfa_pkg::S_IDLE;
            end
            nfa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = nfa_pkg::CMD_START;
                    priority if (!i_status.in_free) begin
                        n_state = nfa_pkg::S_A_ROV;
                    end else if (i_status.in_bad) begin
                        n_state = nfa_pkg::S_RESULT;
                    end else begin
                        n_state = nfa_pkg::S_F_WALK;
                    end
                end
            end
            nfa_pkg::S_A_ROV: begin
                o_cmd   = nfa_pkg::CMD_A_ROV;
                n_state = nfa_pkg::S_A_CHECK;
            end
            nfa_pkg::S_A_CHECK: begin
                o_cmd = nfa_pkg::CMD_A_CHECK;
                priority if (i_status.limit) begin
                    n_state = nfa_pkg::S_RESULT;
                end else if (i_status.fit && i_status.exact) begin
                    n_state = nfa_pkg::S_RESULT;
                end else if (i_status.fit) begin
                    n_state = nfa_pkg::S_A_SPLIT;
                end else if (i_status.at_rover) begin
                    n_state = nfa_pkg::S_RESULT;
                end
            end
            nfa_pkg::S_A_SPLIT: begin
                o_cmd   = nfa_pkg::CMD_A_SPLIT;
                n_state = nfa_pkg::S_RESULT;
            end
            nfa_pkg::S_F_WALK: begin
                o_cmd = nfa_pkg::CMD_F_WALK;
                priority if (i_status.limit) begin
                    n_state = nfa_pkg::S_RESULT;
                end else if (i_status.found) begin
                    n_state = nfa_pkg::S_F_BLK;
                end
            end
            nfa_pkg::S_F_BLK: begin
                o_cmd   = nfa_pkg::CMD_F_BLK;
                n_state = i_status.merge_next ? nfa_pkg::S_F_NX : nfa_pkg::S_F_WB;
            end
            nfa_pkg::S_F_NX: begin
                o_cmd   = nfa_pkg::CMD_F_NX;
                n_state = nfa_pkg::S_F_WB;
            end
            nfa_pkg::S_F_WB: begin
                o_cmd   = nfa_pkg::CMD_F_WB;
                n_state = nfa_pkg::S_F_WP;
            end
            nfa_pkg::S_F_WP: begin
                o_cmd   = nfa_pkg::CMD_F_WP;
                n_state = nfa_pkg::S_RESULT;
            end
            nfa_pkg::S_RESULT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = nfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nfa_pkg::S_IDLE;
            end
        endcase
    end
endmodule

FILE: src/next_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_heap_allocator
// next-fit free-list heap allocator with split on alloc and merge on free
//
//   channel  dir  handshake      payload
//   i_req    in   valid/ready    operation, request_bytes, block_address
//   o_rsp    out  valid/ready    status, data_address, granted_units
//
// one request at a time; one header read per cycle from the header store
// alloc: A_ROV, then A_CHECK per header visited, plus A_SPLIT for a split
// free: F_WALK loop, F_BLK, F_NX to merge, F_WB, F_WP; bad address skips them
// after reset INIT0/INIT1 initialize the sentinel and the initial free block
// a response held on o_rsp does not block the next request transfer
// ----------------------------------------------------------------------------
module next_fit_heap_allocator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nfa_req_if.sink   i_req,
    nfa_rsp_if.source o_rsp
);
    nfa_pkg::t_dp_status          status;
    nfa_pkg::t_cmd                cmd;
    logic                         out_load;
    logic                         out_free;
    logic                         res_status;
    logic [nfa_pkg::IDX_W-1:0]    res_address;
    logic [nfa_pkg::IDX_W-1:0]    res_units;

    logic                         r_out_valid;
    logic                         r_out_status;
    logic [nfa_pkg::IDX_W-1:0]    r_out_address;
    logic [nfa_pkg::IDX_W-1:0]    r_out_units;

    assign out_free = !r_out_valid || o_rsp.ready;

    nfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (i_req.ready),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    nfa_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_req.operation),
        .i_request_bytes (i_req.request_bytes),
        .i_block_address (i_req.block_address),
        .o_status        (status),
        .o_res_status    (res_status),
        .o_res_address   (res_address),
        .o_res_units     (res_units)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status  <= res_status;
            r_out_address <= res_address;
            r_out_units   <= res_units;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.data_address  = r_out_address;
    assign o_rsp.granted_units = r_out_units;
endmodule
